// ===== src/saes_pkg.sv =====
// Shared types, constants and nibble functions for the 16-bit S-AES unit.
`timescale 1ns / 1ps
`default_nettype none

package saes_pkg;

   localparam int BLOCK_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int NIBBLE_W = 4;

   localparam logic [BYTE_W-1:0] RCON1 = 8'h80;
   localparam logic [BYTE_W-1:0] RCON2 = 8'h30;

   localparam logic [NIBBLE_W-1:0] MIX_ENC_DIAG = 4'd1;
   localparam logic [NIBBLE_W-1:0] MIX_ENC_OFF  = 4'd4;
   localparam logic [NIBBLE_W-1:0] MIX_DEC_DIAG = 4'd9;
   localparam logic [NIBBLE_W-1:0] MIX_DEC_OFF  = 4'd2;

   localparam logic [NIBBLE_W-1:0] GF_POLY_LOW = 4'h3;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [NIBBLE_W-1:0] SBOX_FWD [16] = '{
      4'd9, 4'd4, 4'd10, 4'd11, 4'd13, 4'd1, 4'd8, 4'd5,
      4'd6, 4'd2, 4'd0, 4'd3, 4'd12, 4'd14, 4'd15, 4'd7
   };
   localparam logic [NIBBLE_W-1:0] SBOX_INV [16] = '{
      4'd10, 4'd5, 4'd9, 4'd11, 4'd1, 4'd7, 4'd8, 4'd15,
      4'd6, 4'd0, 4'd2, 4'd3, 4'd12, 4'd4, 4'd13, 4'd14
   };

   typedef struct packed {
      logic [BLOCK_W-1:0] rk0;
      logic [BLOCK_W-1:0] rk1;
      logic [BLOCK_W-1:0] rk2;
   } round_keys_type;

   function automatic logic [NIBBLE_W-1:0] gf16_mul(input logic [NIBBLE_W-1:0] a,
                                                   input logic [NIBBLE_W-1:0] b);
      logic [NIBBLE_W-1:0] p;
      logic [NIBBLE_W-1:0] x;
      p = '0;
      x = a;
      for (int i = 0; i < NIBBLE_W; i++) begin
         if (b[i]) begin
            p = p ^ x;
         end
         x = {x[NIBBLE_W-2:0], 1'b0} ^ (x[NIBBLE_W-1] ? GF_POLY_LOW : 4'h0);
      end
      return p;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_nib16(input logic [BLOCK_W-1:0] v,
                                                   input logic inv);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[i*NIBBLE_W +: NIBBLE_W] = inv ? SBOX_INV[v[i*NIBBLE_W +: NIBBLE_W]]
                                         : SBOX_FWD[v[i*NIBBLE_W +: NIBBLE_W]];
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] sub_nib8(input logic [BYTE_W-1:0] v);
      return {SBOX_FWD[v[7:4]], SBOX_FWD[v[3:0]]};
   endfunction

   function automatic logic [BYTE_W-1:0] rot_nib(input logic [BYTE_W-1:0] v);
      return {v[3:0], v[7:4]};
   endfunction

   function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] v,
                                                  input logic [NIBBLE_W-1:0] diag,
                                                  input logic [NIBBLE_W-1:0] off);
      logic [NIBBLE_W-1:0] m0;
      logic [NIBBLE_W-1:0] m1;
      logic [NIBBLE_W-1:0] m2;
      logic [NIBBLE_W-1:0] m3;
      m0 = gf16_mul(diag, v[15:12]) ^ gf16_mul(off, v[11:8]);
      m1 = gf16_mul(off, v[15:12]) ^ gf16_mul(diag, v[11:8]);
      m2 = gf16_mul(diag, v[7:4]) ^ gf16_mul(off, v[3:0]);
      m3 = gf16_mul(off, v[7:4]) ^ gf16_mul(diag, v[3:0]);
      return {m0, m1, m2, m3};
   endfunction

endpackage

`default_nettype wire

// ===== src/simplified_aes_block_cipher_unit.sv =====
// Top level of the 16-bit S-AES unit: key register, input and result registers.
//
//   channel   ports                                   direction  handshake
//   request   start, busy, req_mode, req_data_block   in         start & !busy
//   response  rsp_strobe, rsp_result_block           out        rsp_strobe, one cycle
//   csr       csr_write_enable, csr_write_data       in         csr_write_enable
//
// A word is taken every cycle; it passes the input register and then the result
// register, which drives the result strobe and the result block.
// The input register and the result register bound the cipher logic; key
// expansion runs from the key register in the same cycle as the rounds.
// Synchronous reset clears the key to zero and drops words in flight.
// busy stays low: the receiver cannot stall, so no word is ever held off.
`timescale 1ns / 1ps
`default_nettype none

module simplified_aes_block_cipher_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic [saes_pkg::BLOCK_W-1:0]  req_data_block,
   output logic                               rsp_strobe,
   output logic [saes_pkg::BLOCK_W-1:0]       rsp_result_block,
   input  wire logic                          csr_write_enable,
   input  wire logic [saes_pkg::BLOCK_W-1:0]  csr_write_data
);
   import saes_pkg::*;

   logic                 key_ff;
   logic [BLOCK_W-1:0]   cipher_key_ff;
   logic                 in_valid_ff;
   logic                 in_mode_ff;
   logic [BLOCK_W-1:0]   in_data_ff;
   logic                 rsp_valid_ff;
   logic [BLOCK_W-1:0]   rsp_data_ff;
   logic [BLOCK_W-1:0]   rsp_data_in;
   round_keys_type       round_keys;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff <= '0;
         key_ff        <= 1'b0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cipher_key_ff <= csr_write_data;
            key_ff        <= 1'b1;
         end
         in_valid_ff  <= start && !busy;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_mode_ff <= req_mode;
         in_data_ff <= req_data_block;
      end
      if (in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   saes_key_expand u_key_expand (
      .cipher_key (cipher_key_ff),
      .round_keys (round_keys)
   );

   saes_round_core u_round_core (
      .mode         (in_mode_ff),
      .data_block   (in_data_ff),
      .round_keys   (round_keys),
      .result_block (rsp_data_in)
   );

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_result_block = rsp_data_ff;

   a_start_loads : assert property (@(posedge clock) disable iff (reset)
      start |=> in_valid_ff)
      else $error("accepted word not captured in input register");

   a_valid_advances : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> rsp_strobe)
      else $error("captured word did not reach result register");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> !rsp_strobe)
      else $error("result strobe without a captured word");

   a_key_written : assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (key_ff && cipher_key_ff == $past(csr_write_data)))
      else $error("key register did not take the written word");

endmodule

`default_nettype wire

// ===== src/saes_key_expand.sv =====
// Key expansion: one 16-bit cipher key into three round keys.
`timescale 1ns / 1ps
`default_nettype none

module saes_key_expand (
   input  wire logic [saes_pkg::BLOCK_W-1:0] cipher_key,
   output saes_pkg::round_keys_type          round_keys
);
   import saes_pkg::*;

   logic [BYTE_W-1:0] w0;
   logic [BYTE_W-1:0] w1;
   logic [BYTE_W-1:0] w2;
   logic [BYTE_W-1:0] w3;
   logic [BYTE_W-1:0] w4;
   logic [BYTE_W-1:0] w5;

   always_comb begin
      w0 = cipher_key[15:8];
      w1 = cipher_key[7:0];
      w2 = w0 ^ RCON1 ^ sub_nib8(rot_nib(w1));
      w3 = w2 ^ w1;
      w4 = w2 ^ RCON2 ^ sub_nib8(rot_nib(w3));
      w5 = w4 ^ w3;
      round_keys.rk0 = {w0, w1};
      round_keys.rk1 = {w2, w3};
      round_keys.rk2 = {w4, w5};
   end

endmodule

`default_nettype wire

// ===== src/saes_round_core.sv =====
// Encrypt or decrypt one block through both S-AES rounds.
`timescale 1ns / 1ps
`default_nettype none

module saes_round_core (
   input  wire logic                          mode,
   input  wire logic [saes_pkg::BLOCK_W-1:0]  data_block,
   input  wire saes_pkg::round_keys_type      round_keys,
   output logic [saes_pkg::BLOCK_W-1:0]       result_block
);
   import saes_pkg::*;

   logic [BLOCK_W-1:0] enc_a;
   logic [BLOCK_W-1:0] enc_b;
   logic [BLOCK_W-1:0] enc_out;
   logic [BLOCK_W-1:0] dec_a;
   logic [BLOCK_W-1:0] dec_b;
   logic [BLOCK_W-1:0] dec_out;

   always_comb begin
      enc_a   = data_block ^ round_keys.rk0;
      enc_b   = mix_cols(shift_rows(sub_nib16(enc_a, 1'b0)), MIX_ENC_DIAG, MIX_ENC_OFF)
                ^ round_keys.rk1;
      enc_out = shift_rows(sub_nib16(enc_b, 1'b0)) ^ round_keys.rk2;

      dec_a   = sub_nib16(shift_rows(data_block ^ round_keys.rk2), 1'b1) ^ round_keys.rk1;
      dec_b   = sub_nib16(shift_rows(mix_cols(dec_a, MIX_DEC_DIAG, MIX_DEC_OFF)), 1'b1);
      dec_out = dec_b ^ round_keys.rk0;

      result_block = (mode == MODE_DECRYPT) ? dec_out : enc_out;
   end

endmodule

`default_nettype wire

// ===== tb/simplified_aes_block_cipher_unit_tb.sv =====
// Self-checking testbench for the 16-bit S-AES unit: directed and random words, both modes.
`timescale 1ns / 1ps

module simplified_aes_block_cipher_unit_tb;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_WORDS  = 1950;
   localparam int KEY_PHASES    = 10;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic        busy;
   logic        req_mode         = 1'b0;
   logic [15:0] req_data_block   = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_result_block;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = '0;

   logic [15:0] key_shadow = '0;
   logic [15:0] pending_blocks[$];
   int          fail_count  = 0;
   int          cycle_count = 0;

   simplified_aes_block_cipher_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_data_block   (req_data_block),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_block (rsp_result_block),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic logic [3:0] gf16_times(input logic [3:0] a, input logic [3:0] b);
      logic [3:0] acc;
      logic [3:0] x;
      acc = '0;
      x   = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            acc ^= x;
         end
         x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic logic [15:0] nibble_subst(input logic [15:0] v, input logic inverse);
      logic [15:0] r;
      logic [3:0]  n;
      for (int k = 0; k < 4; k++) begin
         n = v[4*k +: 4];
         if (inverse) begin
            r[4*k +: 4] = saes_pkg::SBOX_INV[n];
         end else begin
            r[4*k +: 4] = saes_pkg::SBOX_FWD[n];
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] row_swap(input logic [15:0] v);
      logic [15:0] r;
      r       = v;
      r[11:8] = v[3:0];
      r[3:0]  = v[11:8];
      return r;
   endfunction

   function automatic logic [15:0] column_mix(input logic [15:0] v, input logic [3:0] d,
                                              input logic [3:0] o);
      logic [15:0] r;
      logic [3:0]  hi;
      logic [3:0]  lo;
      for (int c = 0; c < 2; c++) begin
         hi = v[12 - 8*c +: 4];
         lo = v[8 - 8*c +: 4];
         r[12 - 8*c +: 4] = gf16_times(d, hi) ^ gf16_times(o, lo);
         r[8 - 8*c +: 4]  = gf16_times(o, hi) ^ gf16_times(d, lo);
      end
      return r;
   endfunction

   function automatic logic [15:0] saes_transform(input logic [15:0] key, input logic mode,
                                                  input logic [15:0] block);
      logic [7:0]  w0, w1, w2, w3, w4, w5;
      logic [15:0] t;
      logic [15:0] s;
      w0 = key[15:8];
      w1 = key[7:0];
      t  = nibble_subst({8'h00, w1[3:0], w1[7:4]}, 1'b0);
      w2 = w0 ^ saes_pkg::RCON1 ^ t[7:0];
      w3 = w2 ^ w1;
      t  = nibble_subst({8'h00, w3[3:0], w3[7:4]}, 1'b0);
      w4 = w2 ^ saes_pkg::RCON2 ^ t[7:0];
      w5 = w4 ^ w3;
      if (mode == saes_pkg::MODE_ENCRYPT) begin
         s = block ^ {w0, w1};
         s = column_mix(row_swap(nibble_subst(s, 1'b0)),
                        saes_pkg::MIX_ENC_DIAG, saes_pkg::MIX_ENC_OFF);
         s = s ^ {w2, w3};
         s = row_swap(nibble_subst(s, 1'b0));
         s = s ^ {w4, w5};
      end else begin
         s = block ^ {w4, w5};
         s = nibble_subst(row_swap(s), 1'b1);
         s = s ^ {w2, w3};
         s = nibble_subst(row_swap(column_mix(s, saes_pkg::MIX_DEC_DIAG,
                                              saes_pkg::MIX_DEC_OFF)), 1'b1);
         s = s ^ {w0, w1};
      end
      return s;
   endfunction

   always @(posedge clock) begin : result_check
      logic [15:0] want;
      if (reset) begin
         key_shadow = '0;
      end else begin
         if (rsp_strobe) begin
            if (pending_blocks.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h",
                        $time, rsp_result_block);
               fail_count++;
            end else begin
               want = pending_blocks.pop_front();
               if (rsp_result_block !== want) begin
                  $display("%0t: result_block mismatch: expected %h, actual %h",
                           $time, want, rsp_result_block);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            pending_blocks.push_back(saes_transform(key_shadow, req_mode, req_data_block));
         end
         if (csr_write_enable) begin
            key_shadow = csr_write_data;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simplified_aes_block_cipher_unit regression: fail");
         $finish;
      end
   end

   task automatic send_word(input logic mode, input logic [15:0] block);
      @(negedge clock);
      start          <= 1'b1;
      req_mode       <= mode;
      req_data_block <= block;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start          <= 1'b0;
         req_mode       <= 1'($urandom);
         req_data_block <= 16'($urandom);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [15:0] key);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= key;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= 16'($urandom);
   endtask

   task automatic test_reset_key();
      send_word(saes_pkg::MODE_ENCRYPT, 16'h0000);
      send_word(saes_pkg::MODE_DECRYPT, 16'hFFFF);
      drain_results();
   endtask

   task automatic test_directed_vectors();
      write_key(16'hA73B);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h6F6B);
      send_word(saes_pkg::MODE_DECRYPT, 16'h0738);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h0000);
      send_word(saes_pkg::MODE_DECRYPT, 16'h0000);
      send_word(saes_pkg::MODE_ENCRYPT, 16'hFFFF);
      send_word(saes_pkg::MODE_DECRYPT, 16'hFFFF);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h5555);
      send_word(saes_pkg::MODE_DECRYPT, 16'h5555);
      send_word(saes_pkg::MODE_ENCRYPT, 16'hAAAA);
      send_word(saes_pkg::MODE_DECRYPT, 16'hAAAA);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h000F);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h00F0);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h0F00);
      send_word(saes_pkg::MODE_ENCRYPT, 16'hF000);
      write_key(16'hFFFF);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h0000);
      send_word(saes_pkg::MODE_DECRYPT, 16'hFFFF);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h1234);
      send_word(saes_pkg::MODE_DECRYPT, 16'h1234);
      write_key(16'h0000);
      send_word(saes_pkg::MODE_ENCRYPT, 16'h8001);
      send_word(saes_pkg::MODE_DECRYPT, 16'h7FFE);
      drain_results();
   endtask

   task automatic test_random_traffic();
      int          per_phase;
      int          sent;
      int          burst;
      int          gap;
      int          kind;
      logic [15:0] key;
      logic [15:0] block;
      logic        mode;
      per_phase = RANDOM_WORDS / KEY_PHASES;
      for (int p = 0; p < KEY_PHASES; p++) begin
         case (p)
            0: key = 16'h0000;
            1: key = 16'hFFFF;
            2: key = 16'h8000;
            3: key = 16'h0001;
            default: key = 16'($urandom);
         endcase
         write_key(key);
         sent = 0;
         while (sent < per_phase) begin
            burst = $urandom_range(1, 32);
            for (int b = 0; b < burst && sent < per_phase; b++) begin
               kind = $urandom_range(0, 9);
               mode = 1'($urandom);
               if (kind == 0) begin
                  block = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               end else if (kind == 1) begin
                  mode  = saes_pkg::MODE_DECRYPT;
                  block = saes_transform(key, saes_pkg::MODE_ENCRYPT, 16'($urandom));
               end else begin
                  block = 16'($urandom);
               end
               send_word(mode, block);
               sent++;
               if (p == 5 && sent == per_phase / 2) begin
                  drain_results();
               end
            end
            gap = (p == 4 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            pause_sender(gap);
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_directed_vectors();
      test_random_traffic();
      drain_results();
      if (fail_count == 0 && pending_blocks.size() == 0) begin
         $display("simplified_aes_block_cipher_unit regression: pass");
      end else begin
         if (pending_blocks.size() != 0) begin
            $display("%0t: missing results: expected %0d more, actual 0",
                     $time, pending_blocks.size());
         end
         $display("simplified_aes_block_cipher_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/saes_pkg.sv
src/saes_key_expand.sv
src/saes_round_core.sv
src/simplified_aes_block_cipher_unit.sv
tb/simplified_aes_block_cipher_unit_tb.sv
